@@ src/tstc_pkg.sv @@
// Package for the turn signal and throttle controller.
// Holds the command codes, field widths, report constants and the bar function.
// No dependencies.
package tstc_pkg;

  localparam int unsigned ActionW = 4;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned BarW    = 3;
  localparam int unsigned CfgIdxW = 2;

  // command codes, codes 10..15 carry no command
  typedef enum logic [ActionW-1:0] {
    ActLeftOn   = 4'd0,
    ActLeftOff  = 4'd1,
    ActRightOn  = 4'd2,
    ActRightOff = 4'd3,
    ActHazOn    = 4'd4,
    ActHazOff   = 4'd5,
    ActUp       = 4'd6,
    ActDown     = 4'd7,
    ActSet      = 4'd8,
    ActReport   = 4'd9
  } action_e;

  // config register indexes
  localparam logic [CfgIdxW-1:0] CfgStepAmount   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgReportHeader = 2'd1;

  localparam logic [LevelW-1:0] StepReset   = 8'd25;
  localparam logic [LevelW-1:0] HeaderReset = 8'd0;
  localparam logic [LevelW-1:0] LevelMax    = 8'd255;
  localparam logic [LevelW-1:0] ReportSize  = 8'h01;

  // report beats
  localparam logic [1:0] BeatHeader = 2'd0;
  localparam logic [1:0] BeatSize   = 2'd1;
  localparam logic [1:0] BeatLevel  = 2'd2;
  localparam logic [1:0] BeatSum    = 2'd3;

  // state after one command, handed to the result register
  typedef struct packed {
    logic              left;
    logic              right;
    logic [LevelW-1:0] level;
    logic              is_report;
  } res_t;

  // bar display: one segment per 51-step band, full bar only at 255
  function automatic logic [BarW-1:0] bar_of(input logic [LevelW-1:0] lvl);
    logic [BarW-1:0] bar;
    if (lvl == 8'd0) begin
      bar = 3'd0;
    end else if (lvl <= 8'd51) begin
      bar = 3'd1;
    end else if (lvl <= 8'd102) begin
      bar = 3'd2;
    end else if (lvl <= 8'd153) begin
      bar = 3'd3;
    end else if (lvl <= 8'd204) begin
      bar = 3'd4;
    end else if (lvl <= 8'd254) begin
      bar = 3'd5;
    end else begin
      bar = 3'd6;
    end
    return bar;
  endfunction

endpackage

@@ src/tstc_mode_fsm.sv @@
// Six-state signal mode machine with its fourteen-entry transition table.
// Depends on tstc_pkg.
module tstc_mode_fsm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  tstc_pkg::action_e action_i,
  output logic              left_o,
  output logic              right_o
);

  typedef enum logic [2:0] {
    ModeIdle  = 3'd0,
    ModeLeft  = 3'd1,
    ModeRight = 3'd2,
    ModeHaz   = 3'd3,
    ModeLHaz  = 3'd4,
    ModeRHaz  = 3'd5
  } mode_e;

  mode_e mode_q, mode_d;
  logic  left_q, left_d;
  logic  right_q, right_d;

  always_comb begin
    mode_d  = mode_q;
    left_d  = left_q;
    right_d = right_q;
    unique case (mode_q)
      ModeIdle: begin
        if (action_i == tstc_pkg::ActLeftOn) begin
          mode_d = ModeLeft;  left_d = 1'b1; right_d = 1'b0;
        end else if (action_i == tstc_pkg::ActHazOn) begin
          mode_d = ModeHaz;   left_d = 1'b1; right_d = 1'b1;
        end else if (action_i == tstc_pkg::ActRightOn) begin
          mode_d = ModeRight; left_d = 1'b0; right_d = 1'b1;
        end
      end
      ModeLeft: begin
        if (action_i == tstc_pkg::ActLeftOff) begin
          mode_d = ModeIdle;  left_d = 1'b0; right_d = 1'b0;
        end else if (action_i == tstc_pkg::ActHazOn) begin
          mode_d = ModeLHaz;  left_d = 1'b1; right_d = 1'b1;
        end
      end
      ModeRight: begin
        if (action_i == tstc_pkg::ActRightOff) begin
          mode_d = ModeIdle;  left_d = 1'b0; right_d = 1'b0;
        end else if (action_i == tstc_pkg::ActHazOn) begin
          mode_d = ModeRHaz;  left_d = 1'b1; right_d = 1'b1;
        end
      end
      ModeHaz: begin
        if (action_i == tstc_pkg::ActLeftOn) begin
          mode_d = ModeLHaz;  left_d = 1'b1; right_d = 1'b1;
        end else if (action_i == tstc_pkg::ActHazOff) begin
          mode_d = ModeIdle;  left_d = 1'b0; right_d = 1'b0;
        end else if (action_i == tstc_pkg::ActRightOn) begin
          mode_d = ModeRHaz;  left_d = 1'b1; right_d = 1'b1;
        end
      end
      ModeLHaz: begin
        if (action_i == tstc_pkg::ActHazOff) begin
          mode_d = ModeLeft;  left_d = 1'b1; right_d = 1'b0;
        end else if (action_i == tstc_pkg::ActLeftOff) begin
          mode_d = ModeHaz;   left_d = 1'b1; right_d = 1'b1;
        end
      end
      ModeRHaz: begin
        if (action_i == tstc_pkg::ActHazOff) begin
          mode_d = ModeRight; left_d = 1'b0; right_d = 1'b1;
        end else if (action_i == tstc_pkg::ActRightOff) begin
          mode_d = ModeHaz;   left_d = 1'b1; right_d = 1'b1;
        end
      end
      default: begin
        // unreachable codes: no transition
        mode_d = mode_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      left_q  <= 1'b0;
      right_q <= 1'b0;
    end else if (en_i) begin
      mode_q  <= mode_d;
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  // flags after this command
  assign left_o  = left_d;
  assign right_o = right_d;

endmodule

@@ src/tstc_throttle.sv @@
// Throttle level register: saturating up/down by the step, load on set.
// Depends on tstc_pkg.
module tstc_throttle (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  tstc_pkg::action_e               action_i,
  input  logic [tstc_pkg::LevelW-1:0]     payload_i,
  input  logic [tstc_pkg::LevelW-1:0]     step_i,
  output logic [tstc_pkg::LevelW-1:0]     level_o
);

  logic [tstc_pkg::LevelW-1:0] level_q, level_d;
  logic [tstc_pkg::LevelW:0]   sum;

  assign sum = {1'b0, level_q} + {1'b0, step_i};

  always_comb begin
    level_d = level_q;
    if (action_i == tstc_pkg::ActUp) begin
      level_d = sum[tstc_pkg::LevelW] ? tstc_pkg::LevelMax : sum[tstc_pkg::LevelW-1:0];
    end else if (action_i == tstc_pkg::ActDown) begin
      level_d = (level_q <= step_i) ? '0 : level_q - step_i;
    end else if (action_i == tstc_pkg::ActSet) begin
      level_d = payload_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else if (en_i) begin
      level_q <= level_d;
    end
  end

  assign level_o = level_d;

endmodule

@@ src/tstc_out_stage.sv @@
// Result register with the report beat sequencer; forms tx bytes and the bar.
// Depends on tstc_pkg.
module tstc_out_stage (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  tstc_pkg::res_t                  res_i,
  input  logic [tstc_pkg::LevelW-1:0]     header_i,
  output logic                            free_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            left_lamp_o,
  output logic                            right_lamp_o,
  output logic [tstc_pkg::BarW-1:0]       bar_segments_o,
  output logic                            tx_valid_o,
  output logic [tstc_pkg::LevelW-1:0]     tx_byte_o,
  output logic                            last_o
);

  logic           vld_q;
  logic [1:0]     beat_q;
  tstc_pkg::res_t res_q;
  logic           last_beat;
  logic           take;
  logic [tstc_pkg::LevelW-1:0] sum;

  assign last_beat = !res_q.is_report || (beat_q == tstc_pkg::BeatSum);
  assign take      = vld_q && out_ready_i;
  assign free_o    = !vld_q || (take && last_beat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      beat_q <= tstc_pkg::BeatHeader;
    end else if (load_i) begin
      vld_q  <= 1'b1;
      beat_q <= tstc_pkg::BeatHeader;
    end else if (take) begin
      if (last_beat) begin
        vld_q <= 1'b0;
      end else begin
        beat_q <= beat_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign sum = header_i + tstc_pkg::ReportSize + res_q.level;

  always_comb begin
    tx_byte_o = '0;
    if (res_q.is_report) begin
      unique case (beat_q)
        tstc_pkg::BeatHeader: tx_byte_o = header_i;
        tstc_pkg::BeatSize:   tx_byte_o = tstc_pkg::ReportSize;
        tstc_pkg::BeatLevel:  tx_byte_o = res_q.level;
        tstc_pkg::BeatSum:    tx_byte_o = sum;
        default:              tx_byte_o = '0;
      endcase
    end
  end

  assign out_valid_o    = vld_q;
  assign left_lamp_o    = res_q.left;
  assign right_lamp_o   = res_q.right;
  assign bar_segments_o = tstc_pkg::bar_of(res_q.level);
  assign tx_valid_o     = res_q.is_report;
  assign last_o         = last_beat;

endmodule

@@ src/turn_signal_and_throttle_controller_core.sv @@
// Turn signal and throttle controller, top level.
// Instantiates tstc_mode_fsm, tstc_throttle and tstc_out_stage; uses tstc_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one command item: action_i
//   and payload_i. Output channel (out_valid_o/out_ready_i) gives result
//   items: lamp flags, bar display, tx byte, tx_valid and last.
//   A report command gives four result items (header, 1, level, sum);
//   every other command, including unused codes, gives one.
//   Config channel (cfg_valid_i/cfg_ready_o) writes step amount (index 0)
//   or report header (index 1); other indexes are dropped. Always ready.
//   Write config only while the block is idle.
// Timing:
//   An item lands in the input register at accept; its state update and
//   result load happen together once the result register is free, and
//   out_valid_o rises with that load.
//   Plain commands sustain one item per cycle while the receiver takes every
//   result; a report holds the result register for four output beats.
//   When the receiver stalls, the result register holds and the input
//   register absorbs one more item before in_ready_o drops.
// Reset:
//   rst_ni clears mode (idle), lamp flags, throttle level and both pipeline
//   valids; step amount returns to 25 and report header to 0.
module turn_signal_and_throttle_controller_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [tstc_pkg::ActionW-1:0]        action_i,
  input  logic [tstc_pkg::LevelW-1:0]         payload_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                left_lamp_o,
  output logic                                right_lamp_o,
  output logic [tstc_pkg::BarW-1:0]           bar_segments_o,
  output logic                                tx_valid_o,
  output logic [tstc_pkg::LevelW-1:0]         tx_byte_o,
  output logic                                last_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tstc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [tstc_pkg::LevelW-1:0]         cfg_data_i
);

  // config registers
  logic [tstc_pkg::LevelW-1:0] step_q;
  logic [tstc_pkg::LevelW-1:0] header_q;

  // input register
  logic                        in_vld_q;
  tstc_pkg::action_e           act_q;
  logic [tstc_pkg::LevelW-1:0] pay_q;

  logic                        free;
  logic                        load;
  logic                        left_nx, right_nx;
  logic [tstc_pkg::LevelW-1:0] level_nx;
  tstc_pkg::res_t              res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= tstc_pkg::StepReset;
      header_q <= tstc_pkg::HeaderReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == tstc_pkg::CfgStepAmount) begin
        step_q <= cfg_data_i;
      end else if (cfg_index_i == tstc_pkg::CfgReportHeader) begin
        header_q <= cfg_data_i;
      end
    end
  end

  // the item moves on once the result register can take it
  assign load       = in_vld_q && free;
  assign in_ready_o = !in_vld_q || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q <= tstc_pkg::action_e'(action_i);
      pay_q <= payload_i;
    end
  end

  tstc_mode_fsm u_mode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (load),
    .action_i(act_q),
    .left_o  (left_nx),
    .right_o (right_nx)
  );

  tstc_throttle u_throttle (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (load),
    .action_i (act_q),
    .payload_i(pay_q),
    .step_i   (step_q),
    .level_o  (level_nx)
  );

  always_comb begin
    res.left      = left_nx;
    res.right     = right_nx;
    res.level     = level_nx;
    res.is_report = (act_q == tstc_pkg::ActReport);
  end

  tstc_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .res_i         (res),
    .header_i      (header_q),
    .free_o        (free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .left_lamp_o   (left_lamp_o),
    .right_lamp_o  (right_lamp_o),
    .bar_segments_o(bar_segments_o),
    .tx_valid_o    (tx_valid_o),
    .tx_byte_o     (tx_byte_o),
    .last_o        (last_o)
  );

endmodule

@@ src/tstc_checker.sv @@
// Port-level checks for the controller core, bound to the top level.
// Depends on tstc_pkg.
module tstc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [tstc_pkg::BarW-1:0]     bar_segments_o,
  input logic                          tx_valid_o,
  input logic [tstc_pkg::LevelW-1:0]   tx_byte_o,
  input logic                          last_o
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a plain command gives a single, final result with an empty tx byte
  a_plain_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tx_valid_o |-> last_o && (tx_byte_o == '0))
    else $error("plain result not final or tx byte nonzero");

  // report beats follow each other without a gap
  a_report_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && tx_valid_o && !last_o |=> out_valid_o && tx_valid_o)
    else $error("report packet broken");

  // report header beat is followed by the size byte
  a_report_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && tx_valid_o && !last_o &&
    !$past(out_valid_o && tx_valid_o && !last_o)
    |=> tx_byte_o == tstc_pkg::ReportSize)
    else $error("second report byte is not the size");

  // bar never exceeds six segments
  a_bar_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> bar_segments_o <= 3'd6)
    else $error("bar display out of range");

endmodule

bind turn_signal_and_throttle_controller_core tstc_checker u_tstc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .bar_segments_o(bar_segments_o),
  .tx_valid_o    (tx_valid_o),
  .tx_byte_o     (tx_byte_o),
  .last_o        (last_o)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for turn_signal_and_throttle_controller_core.
// Predicts lamp, bar and report bytes per command and checks every result item.
// Depends on tstc_pkg and the core RTL only.
module tb_top;

  typedef logic [tstc_pkg::ActionW-1:0] act_t;
  typedef logic [tstc_pkg::LevelW-1:0]  lvl_t;
  typedef logic [tstc_pkg::BarW-1:0]    bar_t;
  typedef logic [tstc_pkg::CfgIdxW-1:0] idx_t;

  // mode codes of the lamp state machine, kept on the testbench side only
  typedef enum logic [2:0] {
    ModeIdle     = 3'd0,
    ModeLeft     = 3'd1,
    ModeRight    = 3'd2,
    ModeHaz      = 3'd3,
    ModeLeftHaz  = 3'd4,
    ModeRightHaz = 3'd5
  } lamp_mode_e;

  // action codes that carry no command
  localparam act_t NoCmdLow  = 4'd10;
  localparam act_t NoCmdHigh = 4'd15;
  // register indexes the core drops
  localparam idx_t CfgSpareA = 2'd2;
  localparam idx_t CfgSpareB = 2'd3;

  localparam int QuietLimit    = 2000;
  localparam int RandomPhases  = 6;
  localparam int ItemsPerPhase = 55;

  typedef struct {
    act_t action;
    lvl_t payload;
  } cmd_t;

  typedef struct {
    logic left;
    logic right;
    bar_t bar;
    logic tx_valid;
    lvl_t tx_byte;
    logic is_last;
  } beat_t;

  logic  clk_i          = 1'b0;
  logic  rst_ni         = 1'b0;
  logic  in_valid_i     = 1'b0;
  logic  in_ready_o;
  act_t  action_i       = '0;
  lvl_t  payload_i      = '0;
  logic  out_valid_o;
  logic  out_ready_i    = 1'b0;
  logic  left_lamp_o;
  logic  right_lamp_o;
  bar_t  bar_segments_o;
  logic  tx_valid_o;
  lvl_t  tx_byte_o;
  logic  last_o;
  logic  cfg_valid_i    = 1'b0;
  logic  cfg_ready_o;
  idx_t  cfg_index_i    = '0;
  lvl_t  cfg_data_i     = '0;

  turn_signal_and_throttle_controller_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .payload_i      (payload_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .left_lamp_o    (left_lamp_o),
    .right_lamp_o   (right_lamp_o),
    .bar_segments_o (bar_segments_o),
    .tx_valid_o     (tx_valid_o),
    .tx_byte_o      (tx_byte_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // predicted controller state and register copies
  lamp_mode_e lamp_mode  = ModeIdle;
  logic       left_on    = 1'b0;
  logic       right_on   = 1'b0;
  lvl_t       level      = '0;
  lvl_t       step_cfg   = tstc_pkg::StepReset;
  lvl_t       header_cfg = tstc_pkg::HeaderReset;

  cmd_t  pending_cmds[$];
  beat_t expected_beats[$];
  beat_t want_beat;
  cmd_t  next_cmd;

  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int send_gap       = 0;
  int send_calm      = 0;
  int recv_stall     = 0;
  int recv_calm      = 0;

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatch_count++;
    $display("%0t ns: mismatch on %s, got 0x%0h, want 0x%0h", $time, field, got, want);
  endtask

  // segment count: empty at 0, full only at 255, else one per 51-step band
  function automatic bar_t level_bar(input lvl_t lvl);
    int unsigned band;
    if (lvl == '0) return '0;
    if (lvl == tstc_pkg::LevelMax) return bar_t'(6);
    band = (int'(lvl) - 1) / 51 + 1;
    return bar_t'(band);
  endfunction

  task automatic enter_mode(input lamp_mode_e m, input logic l, input logic r);
    lamp_mode = m;
    left_on   = l;
    right_on  = r;
  endtask

  task automatic push_beat(input logic txv, input lvl_t b, input logic lst);
    beat_t nb;
    nb.left     = left_on;
    nb.right    = right_on;
    nb.bar      = level_bar(level);
    nb.tx_valid = txv;
    nb.tx_byte  = b;
    nb.is_last  = lst;
    expected_beats.push_back(nb);
  endtask

  // advance the predicted state by one accepted command and queue its results
  task automatic predict_command(input act_t act, input lvl_t pay);
    logic [tstc_pkg::LevelW:0] wide_sum;
    lvl_t                      check_byte;
    // lamp transitions; no match leaves mode and lamps alone
    case (lamp_mode)
      ModeIdle: begin
        if (act == tstc_pkg::ActLeftOn) enter_mode(ModeLeft, 1'b1, 1'b0);
        else if (act == tstc_pkg::ActHazOn) enter_mode(ModeHaz, 1'b1, 1'b1);
        else if (act == tstc_pkg::ActRightOn) enter_mode(ModeRight, 1'b0, 1'b1);
      end
      ModeLeft: begin
        if (act == tstc_pkg::ActLeftOff) enter_mode(ModeIdle, 1'b0, 1'b0);
        else if (act == tstc_pkg::ActHazOn) enter_mode(ModeLeftHaz, 1'b1, 1'b1);
      end
      ModeRight: begin
        if (act == tstc_pkg::ActRightOff) enter_mode(ModeIdle, 1'b0, 1'b0);
        else if (act == tstc_pkg::ActHazOn) enter_mode(ModeRightHaz, 1'b1, 1'b1);
      end
      ModeHaz: begin
        if (act == tstc_pkg::ActLeftOn) enter_mode(ModeLeftHaz, 1'b1, 1'b1);
        else if (act == tstc_pkg::ActHazOff) enter_mode(ModeIdle, 1'b0, 1'b0);
        else if (act == tstc_pkg::ActRightOn) enter_mode(ModeRightHaz, 1'b1, 1'b1);
      end
      ModeLeftHaz: begin
        if (act == tstc_pkg::ActHazOff) enter_mode(ModeLeft, 1'b1, 1'b0);
        else if (act == tstc_pkg::ActLeftOff) enter_mode(ModeHaz, 1'b1, 1'b1);
      end
      ModeRightHaz: begin
        if (act == tstc_pkg::ActHazOff) enter_mode(ModeRight, 1'b0, 1'b1);
        else if (act == tstc_pkg::ActRightOff) enter_mode(ModeHaz, 1'b1, 1'b1);
      end
      default: ;
    endcase

    // throttle, saturating both ways
    if (act == tstc_pkg::ActUp) begin
      wide_sum = {1'b0, level} + {1'b0, step_cfg};
      level = wide_sum[tstc_pkg::LevelW] ? tstc_pkg::LevelMax
                                         : wide_sum[tstc_pkg::LevelW-1:0];
    end else if (act == tstc_pkg::ActDown) begin
      level = (level <= step_cfg) ? '0 : level - step_cfg;
    end else if (act == tstc_pkg::ActSet) begin
      level = pay;
    end

    if (act == tstc_pkg::ActReport) begin
      check_byte = header_cfg + tstc_pkg::ReportSize + level;
      push_beat(1'b1, header_cfg, 1'b0);
      push_beat(1'b1, tstc_pkg::ReportSize, 1'b0);
      push_beat(1'b1, level, 1'b0);
      push_beat(1'b1, check_byte, 1'b1);
    end else begin
      push_beat(1'b0, '0, 1'b1);
    end
  endtask

  // mostly no gap, some short, a few long
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // command driver: predicts at accept, then loads the next pending item
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) predict_command(action_i, payload_i);
      if (!in_valid_i || in_ready_o) begin
        if (send_calm > 0) send_calm--;
        else if ($urandom_range(0, 63) == 0) send_calm = $urandom_range(10, 40);
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          next_cmd = pending_cmds.pop_front();
          in_valid_i <= 1'b1;
          action_i   <= next_cmd.action;
          payload_i  <= next_cmd.payload;
          send_gap = (send_calm > 0) ? 0 : idle_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor: compares each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("result with nothing expected", int'(tx_byte_o), 0);
        end else begin
          want_beat = expected_beats.pop_front();
          if (left_lamp_o !== want_beat.left)
            report_mismatch("left_lamp", int'(left_lamp_o), int'(want_beat.left));
          if (right_lamp_o !== want_beat.right)
            report_mismatch("right_lamp", int'(right_lamp_o), int'(want_beat.right));
          if (bar_segments_o !== want_beat.bar)
            report_mismatch("bar_segments", int'(bar_segments_o), int'(want_beat.bar));
          if (tx_valid_o !== want_beat.tx_valid)
            report_mismatch("tx_valid", int'(tx_valid_o), int'(want_beat.tx_valid));
          if (tx_byte_o !== want_beat.tx_byte)
            report_mismatch("tx_byte", int'(tx_byte_o), int'(want_beat.tx_byte));
          if (last_o !== want_beat.is_last)
            report_mismatch("last", int'(last_o), int'(want_beat.is_last));
        end
      end
      if (recv_calm > 0) recv_calm--;
      else if ($urandom_range(0, 63) == 0) recv_calm = $urandom_range(10, 40);
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        recv_stall = (recv_calm > 0) ? 0 : idle_len();
        out_ready_i <= (recv_stall == 0);
        if (recv_stall > 0) recv_stall--;
      end
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input idx_t idx, input lvl_t data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == tstc_pkg::CfgStepAmount) step_cfg = data;
    else if (idx == tstc_pkg::CfgReportHeader) header_cfg = data;
  endtask

  // queue changes happen at the falling edge, away from driver and monitor
  task automatic queue_cmd(input act_t act, input lvl_t pay);
    cmd_t c;
    c.action  = act;
    c.payload = pay;
    pending_cmds.push_back(c);
  endtask

  // sender holds off until every predicted result is back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || in_valid_i || expected_beats.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic cmd_t random_cmd();
    cmd_t        c;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) c.action = act_t'($urandom_range(tstc_pkg::ActLeftOn, tstc_pkg::ActHazOff));
    else if (r < 80) c.action = act_t'($urandom_range(tstc_pkg::ActUp, tstc_pkg::ActSet));
    else if (r < 92) c.action = tstc_pkg::ActReport;
    else c.action = act_t'($urandom_range(NoCmdLow, NoCmdHigh));
    r = $urandom_range(0, 99);
    if (r < 15) c.payload = '0;
    else if (r < 30) c.payload = tstc_pkg::LevelMax;
    else c.payload = lvl_t'($urandom_range(0, 255));
    return c;
  endfunction

  initial begin
    lvl_t step_pick;
    lvl_t header_pick;
    cmd_t rc;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: walk all fourteen transitions, a no-match, saturation and
    // checksum wrap, unused codes, with the reset register values
    @(negedge clk_i);
    queue_cmd(tstc_pkg::ActLeftOff, 8'h00);   // no table entry from idle
    queue_cmd(tstc_pkg::ActLeftOn, 8'hFF);
    queue_cmd(tstc_pkg::ActHazOn, 8'h00);
    queue_cmd(tstc_pkg::ActLeftOff, 8'h00);
    queue_cmd(tstc_pkg::ActRightOn, 8'h00);
    queue_cmd(tstc_pkg::ActHazOff, 8'h00);
    queue_cmd(tstc_pkg::ActRightOff, 8'h00);
    queue_cmd(tstc_pkg::ActHazOn, 8'h00);
    queue_cmd(tstc_pkg::ActLeftOn, 8'h00);
    queue_cmd(tstc_pkg::ActHazOff, 8'h00);
    queue_cmd(tstc_pkg::ActLeftOff, 8'h00);
    queue_cmd(tstc_pkg::ActRightOn, 8'h00);
    queue_cmd(tstc_pkg::ActHazOn, 8'h00);
    queue_cmd(tstc_pkg::ActRightOff, 8'h00);
    queue_cmd(tstc_pkg::ActHazOff, 8'h00);
    queue_cmd(tstc_pkg::ActReport, 8'h00);    // level zero
    queue_cmd(tstc_pkg::ActSet, tstc_pkg::LevelMax);
    queue_cmd(tstc_pkg::ActUp, 8'h00);        // clamps at full
    queue_cmd(tstc_pkg::ActReport, 8'h00);    // checksum wraps to zero
    queue_cmd(tstc_pkg::ActSet, 8'd51);
    queue_cmd(tstc_pkg::ActUp, 8'd52);
    queue_cmd(tstc_pkg::ActSet, 8'd254);
    queue_cmd(tstc_pkg::ActDown, 8'h00);
    queue_cmd(tstc_pkg::ActSet, 8'd10);
    queue_cmd(tstc_pkg::ActDown, 8'h00);      // clamps at zero
    queue_cmd(NoCmdLow, tstc_pkg::LevelMax);
    queue_cmd(NoCmdHigh, 8'h55);
    wait_drained();

    for (int phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0: begin
          step_pick   = '0;
          header_pick = 8'hFF;
        end
        1: begin
          step_pick   = 8'hFF;
          header_pick = '0;
        end
        2: begin
          step_pick   = 8'd1;
          header_pick = 8'hA5;
        end
        3: begin
          step_pick   = tstc_pkg::StepReset;
          header_pick = lvl_t'($urandom_range(0, 255));
        end
        default: begin
          step_pick   = lvl_t'($urandom_range(0, 255));
          header_pick = lvl_t'($urandom_range(0, 255));
        end
      endcase
      write_reg(tstc_pkg::CfgStepAmount, step_pick);
      write_reg(tstc_pkg::CfgReportHeader, header_pick);
      // dropped indexes must leave both registers alone
      write_reg(phase[0] ? CfgSpareB : CfgSpareA, lvl_t'($urandom_range(0, 255)));
      @(negedge clk_i);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        rc = random_cmd();
        pending_cmds.push_back(rc);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
